FILE: sv/rtm_pkg.sv
// ----------------------------------------------------------------------------
// rtm_pkg: shared types, constants and helpers for the reserved TLD matcher
// Word patterns, enable bit positions and the item and tail structures.
// ----------------------------------------------------------------------------
`default_nettype none

package rtm_pkg;

  localparam int unsigned WinBytes = 12;
  localparam int unsigned WinBits  = WinBytes * 8;
  localparam int unsigned MaskBits = 7;

  // Enable bit positions
  localparam int unsigned EnTest        = 0;
  localparam int unsigned EnExample     = 1;
  localparam int unsigned EnInvalid     = 2;
  localparam int unsigned EnLocalhost   = 3;
  localparam int unsigned EnLocaldomain = 4;
  localparam int unsigned EnLocal       = 5;
  localparam int unsigned EnLan         = 6;

  localparam logic [MaskBits-1:0] MaskReset = 7'h7f;

  // String literals pack the last character into the lowest byte, which
  // matches the window layout (newest byte in [7:0]).
  localparam logic [39:0] WordTest        = ".test";
  localparam logic [63:0] WordExample     = ".example";
  localparam logic [63:0] WordInvalid     = ".invalid";
  localparam logic [79:0] WordLocalhost   = ".localhost";
  localparam logic [95:0] WordLocaldomain = ".localdomain";
  localparam logic [47:0] WordLocal       = ".local";
  localparam logic [31:0] WordLan         = ".lan";
  localparam logic [63:0] LabelExample    = "example.";

  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChHyphen = 8'h2d;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [WinBits-1:0] win;
    logic               label_hit;
  } tail_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  // Called on folded bytes, so upper case never reaches it.
  function automatic logic is_word_byte(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7a) || (b == ChHyphen);
  endfunction

endpackage

`default_nettype wire

FILE: sv/rtm_in_stage.sv
// ----------------------------------------------------------------------------
// rtm_in_stage: input register
// Holds one request until the window stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtm_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire rtm_pkg::item_t item_i,
  output logic               valid_o,
  output rtm_pkg::item_t     item_o,
  input  wire logic          take_i
);

  logic           valid_q, valid_d;
  rtm_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: sv/rtm_window.sv
// ----------------------------------------------------------------------------
// rtm_window: folded tail window, position count and example label flag
// Presents the post-update tail for the matcher; clears after the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rtm_window (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire rtm_pkg::item_t item_i,
  output rtm_pkg::tail_t      tail_o
);

  logic [rtm_pkg::WinBits-1:0] win_q, win_d, win_shift;
  logic [3:0]                  pos_q, pos_d;
  logic                        label_q, label_d, label_upd;
  logic [7:0]                  b;
  logic [7:0]                  prev;

  always_comb begin
    b         = rtm_pkg::fold_byte(item_i.text_byte);
    win_shift = {win_q[rtm_pkg::WinBits-9:0], b};
    prev      = win_shift[71:64];
    label_upd = label_q;
    if (b == rtm_pkg::ChDot) begin
      label_upd = 1'b0;
      if (pos_q >= 4'd7 && win_shift[63:0] == rtm_pkg::LabelExample) begin
        // label at string start, or preceded by a non-label byte
        label_upd = (pos_q == 4'd7) || !rtm_pkg::is_word_byte(prev);
      end
    end
  end

  always_comb begin
    win_d   = win_q;
    pos_d   = pos_q;
    label_d = label_q;
    if (step_i) begin
      if (item_i.end_of_text) begin
        win_d   = '0;
        pos_d   = '0;
        label_d = 1'b0;
      end else begin
        win_d   = win_shift;
        pos_d   = (pos_q == 4'd15) ? pos_q : pos_q + 4'd1;
        label_d = label_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      label_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      label_q <= label_d;
    end
  end

  assign tail_o.win       = win_shift;
  assign tail_o.label_hit = label_upd;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.end_of_text) |=> (win_q == '0 && pos_q == 4'd0 && !label_q))
    else $error("window not cleared after last byte");

  a_pos_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!step_i) |=> $stable(pos_q) && $stable(win_q))
    else $error("window moved without a step");

endmodule

`default_nettype wire

FILE: sv/rtm_match.sv
// ----------------------------------------------------------------------------
// rtm_match: reserved word compare
// Compares the tail against each enabled word, plus the example label flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rtm_match (
  input  wire rtm_pkg::tail_t               tail_i,
  input  wire logic [rtm_pkg::MaskBits-1:0] mask_i,
  output logic                              hit_o
);

  logic [rtm_pkg::MaskBits-1:0] eq;

  always_comb begin
    eq = '0;
    eq[rtm_pkg::EnTest]        = (tail_i.win[39:0] == rtm_pkg::WordTest);
    eq[rtm_pkg::EnExample]     = (tail_i.win[63:0] == rtm_pkg::WordExample)
                                 || tail_i.label_hit;
    eq[rtm_pkg::EnInvalid]     = (tail_i.win[63:0] == rtm_pkg::WordInvalid);
    eq[rtm_pkg::EnLocalhost]   = (tail_i.win[79:0] == rtm_pkg::WordLocalhost);
    eq[rtm_pkg::EnLocaldomain] = (tail_i.win[95:0] == rtm_pkg::WordLocaldomain);
    eq[rtm_pkg::EnLocal]       = (tail_i.win[47:0] == rtm_pkg::WordLocal);
    eq[rtm_pkg::EnLan]         = (tail_i.win[31:0] == rtm_pkg::WordLan);
  end

  assign hit_o = |(eq & mask_i);

endmodule

`default_nettype wire

FILE: sv/reserved_tld_matcher.sv
// ----------------------------------------------------------------------------
// reserved_tld_matcher: flags strings ending in a reserved top-level domain
// Byte stream in, one result per string out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one byte of a domain or address per request, with
//   tlast on the final byte. The master stream gives one result per string,
//   on the request that carried tlast; other bytes give no result.
//   cfg_we_i/cfg_wdata_i write the 7-bit word enable mask (reset: all on);
//   write it only while no string is in flight.
//   A final byte passes the input register and then the result register
//   before its result appears on the master side.
//   Throughput: one byte per cycle while no held result stalls a final byte;
//   the window update and all word compares sit between the two registers.
//   Stall: a result held by the receiver stalls only a further final byte;
//   ordinary bytes keep flowing into the window. The input register then
//   fills and tready drops.
//   Reset: window, count and flag clear, mask goes to all enabled, both
//   stream sides empty.
// ----------------------------------------------------------------------------
`default_nettype none

module reserved_tld_matcher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] text_byte
  input  wire logic                        s_axis_tlast,  // end_of_text
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [0] is_reserved, rest zero
  input  wire logic                        cfg_we_i,
  input  wire logic [rtm_pkg::MaskBits-1:0] cfg_wdata_i
);

  logic [rtm_pkg::MaskBits-1:0] mask_q;
  rtm_pkg::item_t               in_item, s0_item;
  rtm_pkg::tail_t               tail;
  logic                         s0_valid, s0_take, out_free, hit;
  logic                         out_valid_q, out_valid_d;
  logic                         out_bit_q;

  assign in_item.text_byte   = s_axis_tdata;
  assign in_item.end_of_text = s_axis_tlast;

  rtm_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (s0_valid),
    .item_o  (s0_item),
    .take_i  (s0_take)
  );

  // A final byte needs a free result slot; others always move on.
  assign out_free = !out_valid_q || m_axis_tready;
  assign s0_take  = s0_valid && (!s0_item.end_of_text || out_free);

  rtm_window u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s0_take),
    .item_i (s0_item),
    .tail_o (tail)
  );

  rtm_match u_match (
    .tail_i (tail),
    .mask_i (mask_q),
    .hit_o  (hit)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (s0_take && s0_item.end_of_text) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mask_q      <= rtm_pkg::MaskReset;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_take && s0_item.end_of_text) begin
      out_bit_q <= hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_bit_q};

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s0_take && s0_item.end_of_text))
    else $error("result without a final byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && s0_valid && s0_item.end_of_text) |-> !s0_take)
    else $error("held result overwritten");

  a_mask_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_take && s0_item.end_of_text && mask_q == '0) |=> !out_bit_q)
    else $error("match reported with all words disabled");

endmodule

`default_nettype wire
